// ===== sv/tts_pkg.sv =====
// shared types and constants for the transposition table store
`default_nettype none

package tts_pkg;

    localparam int ENTRIES = 65536;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int USED_W  = 17;
    localparam int DATA_W  = 56;
    localparam int KEY_W   = 64;

    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_STORE  = 2'd1;
    localparam logic [1:0] MODE_AGE    = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    typedef enum logic [1:0] {
        OP_LOOKUP,
        OP_STORE,
        OP_AGE,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [KEY_W-1:0]   key;
        logic [7:0]         depth;
        logic signed [15:0] score;
        logic [7:0]         kind;
        logic [15:0]        move;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic [KEY_W-1:0]  check;
        logic [DATA_W-1:0] data;
    } t_entry;

endpackage

`default_nettype wire

// ===== sv/transposition_table_store.sv =====
// a lookup or store goes from the queue slot to the item and read-data registers, then its result to o_done
// throughput: one lookup or store per cycle in a run, set by the table's single read port
// new search aging is done in the idle state; clear walks the table and writes every slot
// reset: synchronous, then a wipe of every table slot with busy held high
// results cannot be stalled; each appears for one cycle with o_done
`default_nettype none

module transposition_table_store (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         i_mode,
    input  wire logic [63:0]        i_pos_key,
    input  wire logic [7:0]         i_search_depth,
    input  wire logic signed [15:0] i_score,
    input  wire logic [7:0]         i_bound_kind,
    input  wire logic [15:0]        i_best_move,
    output logic                    o_done,
    output logic                    o_hit,
    output logic [7:0]              o_found_depth,
    output logic signed [15:0]      o_found_score,
    output logic [7:0]              o_found_kind,
    output logic [15:0]             o_found_move,
    output logic [16:0]             o_used_count
);
    import tts_pkg::*;

    t_cmd    push_cmd;
    t_cmd    head;
    t_q_stat q_stat;
    logic    push;
    logic    pop;
    logic    init_busy;

    tts_front u_front (
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_pos_key      (i_pos_key),
        .i_search_depth (i_search_depth),
        .i_score        (i_score),
        .i_bound_kind   (i_bound_kind),
        .i_best_move    (i_best_move),
        .i_q_stat       (q_stat),
        .i_init_busy    (init_busy),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    tts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    tts_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_q_stat      (q_stat),
        .o_pop         (pop),
        .o_init_busy   (init_busy),
        .o_done        (o_done),
        .o_hit         (o_hit),
        .o_found_depth (o_found_depth),
        .o_found_score (o_found_score),
        .o_found_kind  (o_found_kind),
        .o_found_move  (o_found_move),
        .o_used_count  (o_used_count)
    );

endmodule

`default_nettype wire

// ===== sv/tts_front.sv =====
// front end: accepts items, decodes the mode and pushes commands into the queue
`default_nettype none

module tts_front (
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         i_mode,
    input  wire logic [63:0]        i_pos_key,
    input  wire logic [7:0]         i_search_depth,
    input  wire logic signed [15:0] i_score,
    input  wire logic [7:0]         i_bound_kind,
    input  wire logic [15:0]        i_best_move,
    input  wire tts_pkg::t_q_stat   i_q_stat,
    input  wire logic               i_init_busy,
    output logic                    o_push,
    output tts_pkg::t_cmd           o_cmd
);
    import tts_pkg::*;

    t_op op;

    always_comb begin
        case (i_mode)
            MODE_LOOKUP: op = OP_LOOKUP;
            MODE_STORE:  op = OP_STORE;
            MODE_AGE:    op = OP_AGE;
            MODE_CLEAR:  op = OP_CLEAR;
            default:     op = OP_LOOKUP;
        endcase
    end

    // hold off while the queue is full or the table is being wiped after reset
    assign busy   = i_q_stat.full | i_init_busy;
    assign o_push = start & ~busy;

    always_comb begin
        o_cmd.op    = op;
        o_cmd.key   = i_pos_key;
        o_cmd.depth = i_search_depth;
        o_cmd.score = i_score;
        o_cmd.kind  = i_bound_kind;
        o_cmd.move  = i_best_move;
    end

endmodule

`default_nettype wire

// ===== sv/tts_queue.sv =====
// two-entry command queue between front and back
`default_nettype none

module tts_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire tts_pkg::t_cmd    i_cmd,
    input  wire logic             i_pop,
    output tts_pkg::t_cmd         o_head,
    output tts_pkg::t_q_stat      o_stat
);
    import tts_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_head       = r_slot[r_rd_ptr];
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);

endmodule

`default_nettype wire

// ===== sv/tts_back.sv =====
// back end: table memory, age and free count, lookup/store/age/clear execution
`default_nettype none

module tts_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tts_pkg::t_cmd      i_head,
    input  wire tts_pkg::t_q_stat   i_q_stat,
    output logic                    o_pop,
    output logic                    o_init_busy,
    output logic                    o_done,
    output logic                    o_hit,
    output logic [7:0]              o_found_depth,
    output logic signed [15:0]      o_found_score,
    output logic [7:0]              o_found_kind,
    output logic [15:0]             o_found_move,
    output logic [16:0]             o_used_count
);
    import tts_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_CLEAR
    } t_state;

    t_entry r_mem [ENTRIES];
    t_entry r_rd_data;

    t_state             r_state, n_state;
    t_cmd               r_item, n_item;
    logic [7:0]         r_age, n_age;
    logic [USED_W-1:0]  r_free, n_free;
    logic [IDX_W-1:0]   r_clr_idx, n_clr_idx;
    logic               r_clr_report, n_clr_report;
    logic               n_done, n_hit;
    logic [7:0]         n_fdepth, n_fkind;
    logic signed [15:0] n_fscore;
    logic [15:0]        n_fmove;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    t_entry             wr_data;
    logic [IDX_W-1:0]   rd_addr;

    logic [DATA_W-1:0]  old_data;
    logic [7:0]         old_age;
    logic [7:0]         old_depth;
    logic [DATA_W-1:0]  new_data;
    logic               head_is_mem;

    assign rd_addr     = i_head.key[IDX_W-1:0];
    assign old_data    = r_rd_data.data;
    assign old_age     = old_data[7:0];
    assign old_depth   = old_data[15:8];
    assign new_data    = {r_item.kind, r_item.move, r_item.score, r_item.depth, r_age};
    assign head_is_mem = (i_head.op == OP_LOOKUP) | (i_head.op == OP_STORE);

    // write-first read so a back-to-back item on the same slot sees the update
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (wr_en && (wr_addr == rd_addr)) begin
            r_rd_data <= wr_data;
        end else begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_age        = r_age;
        n_free       = r_free;
        n_clr_idx    = r_clr_idx;
        n_clr_report = r_clr_report;
        n_done       = 1'b0;
        n_hit        = 1'b0;
        n_fdepth     = 8'd0;
        n_fscore     = 16'sd0;
        n_fkind      = 8'd0;
        n_fmove      = 16'd0;
        o_pop        = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = r_item.key[IDX_W-1:0];
        wr_data      = '0;

        case (r_state)
            S_CLEAR: begin
                wr_en     = 1'b1;
                wr_addr   = r_clr_idx;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == {IDX_W{1'b1}}) begin
                    n_state      = S_IDLE;
                    n_done       = r_clr_report;
                    n_clr_report = 1'b0;
                end
            end
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    case (i_head.op)
                        OP_LOOKUP, OP_STORE: begin
                            n_item  = i_head;
                            n_state = S_EXEC;
                        end
                        OP_AGE: begin
                            n_age  = r_age + 8'd1;
                            n_free = USED_W'(ENTRIES);
                            n_done = 1'b1;
                        end
                        default: begin
                            n_age        = 8'd0;
                            n_free       = USED_W'(ENTRIES);
                            n_clr_idx    = '0;
                            n_clr_report = 1'b1;
                            n_state      = S_CLEAR;
                        end
                    endcase
                end
            end
            S_EXEC: begin
                n_done = 1'b1;
                if (r_item.op == OP_LOOKUP) begin
                    if (r_rd_data.check == (r_item.key ^ {8'd0, old_data})) begin
                        n_hit    = 1'b1;
                        n_fdepth = old_data[15:8];
                        n_fscore = old_data[31:16];
                        n_fmove  = old_data[47:32];
                        n_fkind  = old_data[55:48];
                    end
                end else if ((old_age != r_age) || (old_depth <= r_item.depth)) begin
                    // slot counts as newly filled when empty or from an older search
                    if (((old_depth == 8'd0) || (old_age < r_age)) && (r_free != '0)) begin
                        n_free = r_free - 1'b1;
                    end
                    wr_en         = 1'b1;
                    wr_data.data  = new_data;
                    wr_data.check = r_item.key ^ {8'd0, new_data};
                end
                if (!i_q_stat.empty && head_is_mem) begin
                    o_pop  = 1'b1;
                    n_item = i_head;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_age        <= 8'd0;
            r_free       <= USED_W'(ENTRIES);
            r_clr_idx    <= '0;
            r_clr_report <= 1'b0;
            o_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_age        <= n_age;
            r_free       <= n_free;
            r_clr_idx    <= n_clr_idx;
            r_clr_report <= n_clr_report;
            o_done       <= n_done;
        end
        r_item        <= n_item;
        o_hit         <= n_hit;
        o_found_depth <= n_fdepth;
        o_found_score <= n_fscore;
        o_found_kind  <= n_fkind;
        o_found_move  <= n_fmove;
        o_used_count  <= USED_W'(ENTRIES) - n_free;
    end

    assign o_init_busy = (r_state == S_CLEAR) & ~r_clr_report;

endmodule

`default_nettype wire

// ===== sv/tts_checker.sv =====
// port-level checks for the transposition table store, bound to the top level
`default_nettype none

module tts_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               busy,
    input wire logic               o_done,
    input wire logic               o_hit,
    input wire logic [7:0]         o_found_depth,
    input wire logic signed [15:0] o_found_score,
    input wire logic [7:0]         o_found_kind,
    input wire logic [15:0]        o_found_move,
    input wire logic [16:0]        o_used_count
);
    import tts_pkg::*;

    // the wipe after reset keeps the block closed to new items
    a_busy_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("busy low right after reset");

    a_no_done_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_done)
        else $error("result strobe right after reset");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_hit) |-> (o_found_depth == 8'd0 && o_found_score == 16'sd0 &&
                                o_found_kind == 8'd0 && o_found_move == 16'd0))
        else $error("miss result carries nonzero fields");

    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_used_count <= USED_W'(ENTRIES)))
        else $error("used count above table size");

endmodule

bind transposition_table_store tts_checker u_tts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .busy          (busy),
    .o_done        (o_done),
    .o_hit         (o_hit),
    .o_found_depth (o_found_depth),
    .o_found_score (o_found_score),
    .o_found_kind  (o_found_kind),
    .o_found_move  (o_found_move),
    .o_used_count  (o_used_count)
);

`default_nettype wire
